@@ rtl/ssb_pkg.sv @@
`timescale 1ns / 1ps

package ssb_pkg;

   // Sizes of the weight set and of the sums.
   localparam int MAX_WEIGHTS = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int SUM_BITS    = 20;
   localparam int COUNT_BITS  = $clog2(MAX_WEIGHTS + 1);
   localparam int IDX_BITS    = $clog2(MAX_WEIGHTS);
   localparam int FUNC_BITS   = 2;
   localparam int MASK_BITS   = 16;

   // Request function codes.
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_FIND  = 2'd2;

   typedef enum logic [2:0] {
      ST_SOLUTION  = 3'd0,
      ST_EXHAUSTED = 3'd1,
      ST_CANNOT    = 3'd2,
      ST_FULL      = 3'd3,
      ST_ACK       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ENTER  = 2'd1,
      PH_RETURN = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE   = 2'd0,
      CS_EXEC   = 2'd1,
      CS_WALK   = 2'd2,
      CS_FINISH = 2'd3
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_CLEAR = 3'd1,
      OP_LOAD  = 3'd2,
      OP_START = 3'd3,
      OP_STEP  = 3'd4
   } dp_op_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [15:0]          weight_value;
   } req_word_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] subset_mask;
      logic [2:0]           status;
   } rsp_word_type;

   // Controller to datapath.
   typedef struct packed {
      logic       take;
      dp_op_type  op;
      logic       rsp_load;
      status_type rsp_status;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic                 set_full;
      logic                 phase_idle;
      logic                 phase_done;
      logic                 below_target;
      logic                 step_found;
      logic                 step_end;
      logic                 rsp_busy;
   } dp_stat_type;

endpackage

@@ rtl/ssb_ctrl.sv @@
`timescale 1ns / 1ps

module ssb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ssb_pkg::dp_stat_type stat,
   output ssb_pkg::dp_cmd_type  cmd
);
   import ssb_pkg::*;

   ctrl_state_type state_ff, state_in;
   status_type     result_ff, result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CS_IDLE;
         result_ff <= ST_ACK;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      result_in      = result_ff;
      req_stall      = (state_ff != CS_IDLE);
      cmd.take       = 1'b0;
      cmd.op         = OP_NONE;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = result_ff;

      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = CS_EXEC;
            end
         end
         CS_EXEC: begin
            state_in  = CS_FINISH;
            result_in = ST_ACK;
            unique case (stat.func)
               FUNC_CLEAR: cmd.op = OP_CLEAR;
               FUNC_LOAD: begin
                  if (stat.set_full) begin
                     result_in = ST_FULL;
                  end else begin
                     cmd.op = OP_LOAD;
                  end
               end
               FUNC_FIND: begin
                  priority if (stat.phase_idle && stat.below_target) begin
                     result_in = ST_CANNOT;
                  end else if (stat.phase_idle) begin
                     cmd.op   = OP_START;
                     state_in = CS_WALK;
                  end else if (stat.phase_done) begin
                     result_in = ST_EXHAUSTED;
                  end else begin
                     state_in = CS_WALK;
                  end
               end
               default: result_in = ST_ACK;
            endcase
         end
         CS_WALK: begin
            cmd.op = OP_STEP;
            priority if (stat.step_found) begin
               result_in = ST_SOLUTION;
               state_in  = CS_FINISH;
            end else if (stat.step_end) begin
               result_in = ST_EXHAUSTED;
               state_in  = CS_FINISH;
            end
         end
         CS_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

endmodule

@@ rtl/ssb_dp.sv @@
`timescale 1ns / 1ps

module ssb_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  ssb_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ssb_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_write,
   input  logic [ssb_pkg::SUM_BITS-1:0] csr_wdata,
   input  ssb_pkg::dp_cmd_type          cmd,
   output ssb_pkg::dp_stat_type         stat
);
   import ssb_pkg::*;

   // Sorted weight store; entries at or above the count are never read.
   logic [WEIGHT_BITS-1:0] weights_ff [MAX_WEIGHTS];
   logic [WEIGHT_BITS-1:0] weights_in [MAX_WEIGHTS];

   req_word_type           req_ff;
   logic [SUM_BITS-1:0]    target_ff, target_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SUM_BITS-1:0]    total_ff, total_in;
   // A set bit below the depth also means only the include branch has been tried.
   logic [MAX_WEIGHTS-1:0] mask_ff, mask_in;
   logic [COUNT_BITS-1:0]  depth_ff, depth_in;
   logic [SUM_BITS-1:0]    run_ff, run_in;
   logic [SUM_BITS-1:0]    rem_ff, rem_in;
   phase_type              phase_ff, phase_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [WEIGHT_BITS-1:0] load_value;
   logic [WEIGHT_BITS-1:0] prev_weight [MAX_WEIGHTS];
   logic [MAX_WEIGHTS-1:0] gt_prev, gt_self;
   logic [COUNT_BITS-1:0]  parent;
   logic [IDX_BITS-1:0]    rd_idx;
   logic [SUM_BITS-1:0]    rd_weight;
   logic                   reach, at_target, fits, node_ok;
   logic                   step_found, step_end;

   assign load_value = req_ff.weight_value[WEIGHT_BITS-1:0];
   assign parent     = depth_ff - COUNT_BITS'(1);
   assign rd_idx     = (phase_ff == PH_RETURN) ? parent[IDX_BITS-1:0]
                                               : depth_ff[IDX_BITS-1:0];
   assign rd_weight  = SUM_BITS'(weights_ff[rd_idx]);

   assign reach     = ({1'b0, run_ff} + {1'b0, rem_ff}) >= {1'b0, target_ff};
   assign at_target = (run_ff == target_ff);
   assign fits      = (depth_ff < count_ff) &&
                      (({1'b0, run_ff} + {1'b0, rd_weight}) <= {1'b0, target_ff});
   assign node_ok   = reach && (at_target || fits);

   // Insertion cells: each entry compares against the new weight in parallel.
   always_comb begin
      gt_prev[0]     = 1'b0;
      prev_weight[0] = '0;
      for (int i = 0; i < MAX_WEIGHTS; i++) begin
         gt_self[i] = (COUNT_BITS'(i) < count_ff) && (weights_ff[i] > load_value);
      end
      for (int i = 1; i < MAX_WEIGHTS; i++) begin
         gt_prev[i]     = gt_self[i-1];
         prev_weight[i] = weights_ff[i-1];
      end
   end

   always_comb begin
      weights_in   = weights_ff;
      target_in    = csr_write ? csr_wdata : target_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      mask_in      = mask_ff;
      depth_in     = depth_ff;
      run_in       = run_ff;
      rem_in       = rem_ff;
      phase_in     = phase_ff;
      step_found   = 1'b0;
      step_end     = 1'b0;

      unique case (cmd.op)
         OP_NONE: ;
         OP_CLEAR: begin
            count_in = '0;
            total_in = '0;
            mask_in  = '0;
            depth_in = '0;
            run_in   = '0;
            rem_in   = '0;
            phase_in = PH_IDLE;
         end
         OP_LOAD: begin
            for (int i = 0; i < MAX_WEIGHTS; i++) begin
               if (gt_prev[i]) begin
                  weights_in[i] = prev_weight[i];
               end else if (gt_self[i] || (COUNT_BITS'(i) == count_ff)) begin
                  weights_in[i] = load_value;
               end
            end
            count_in = count_ff + COUNT_BITS'(1);
            total_in = total_ff + SUM_BITS'(load_value);
            mask_in  = '0;
            depth_in = '0;
            run_in   = '0;
            rem_in   = '0;
            phase_in = PH_IDLE;
         end
         OP_START: begin
            mask_in  = '0;
            depth_in = '0;
            run_in   = '0;
            rem_in   = total_ff;
            phase_in = PH_ENTER;
         end
         OP_STEP: begin
            unique case (phase_ff)
               PH_ENTER: begin
                  priority if (!node_ok) begin
                     phase_in = PH_RETURN;
                  end else if (at_target) begin
                     step_found = 1'b1;
                     phase_in   = PH_RETURN;
                  end else begin
                     // Include branch at this depth.
                     mask_in[depth_ff[IDX_BITS-1:0]] = 1'b1;
                     run_in   = run_ff + rd_weight;
                     rem_in   = rem_ff - rd_weight;
                     depth_in = depth_ff + COUNT_BITS'(1);
                  end
               end
               PH_RETURN: begin
                  priority if (depth_ff == '0) begin
                     step_end = 1'b1;
                     phase_in = PH_DONE;
                  end else if (mask_ff[parent[IDX_BITS-1:0]]) begin
                     // Switch the parent to its exclude branch.
                     mask_in[parent[IDX_BITS-1:0]] = 1'b0;
                     run_in   = run_ff - rd_weight;
                     phase_in = PH_ENTER;
                  end else begin
                     rem_in   = rem_ff + rd_weight;
                     depth_in = parent;
                  end
               end
               default: begin
                  step_end = 1'b1;
                  phase_in = PH_DONE;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.status      = cmd.rsp_status;
         rsp_word_in.subset_mask = (cmd.rsp_status == ST_SOLUTION) ?
                                   MASK_BITS'(mask_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      weights_in_loop : for (int i = 0; i < MAX_WEIGHTS; i++) begin
         weights_ff[i] <= weights_in[i];
      end
      rsp_word_ff <= rsp_word_in;
      if (cmd.take) begin
         req_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         mask_ff      <= '0;
         depth_ff     <= '0;
         run_ff       <= '0;
         rem_ff       <= '0;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         mask_ff      <= mask_in;
         depth_ff     <= depth_in;
         run_ff       <= run_in;
         rem_ff       <= rem_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.func         = req_ff.func;
   assign stat.set_full     = (count_ff >= COUNT_BITS'(MAX_WEIGHTS));
   assign stat.phase_idle   = (phase_ff == PH_IDLE);
   assign stat.phase_done   = (phase_ff == PH_DONE);
   assign stat.below_target = (total_ff < target_ff);
   assign stat.step_found   = step_found;
   assign stat.step_end     = step_end;
   assign stat.rsp_busy     = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/subset_sum_backtracking.sv @@
`timescale 1ns / 1ps

// Subset-sum search engine. Weights are loaded one word at a time on the
// request channel and kept in ascending order; each find request resumes a
// depth-first search and returns the next subset summing to target_sum, if any.
// The request channel (req_valid, req_stall, req_word) carries a function code
// and a weight; the response channel (rsp_valid, rsp_stall, rsp_word) returns
// one word per request: a subset mask over sorted positions and a status.
// target_sum is to be written through csr_write and csr_wdata only while the
// block is idle; the block itself does not enforce this. A clear, a load or a
// find that needs no search passes from the accepted request through the
// execute and finish states into the output register. A find that walks the
// tree also passes through the walk state, where the single-step walk unit
// takes one tree step (one node entry or one backtrack) at a time. One request
// is in flight at a time; the block takes the next request once the previous
// response sits in the output register, even while that word is still stalled.
// If the receiver stalls, the response holds and the block waits to hand over
// the following response. A synchronous reset empties the weight set, clears
// the search, sets target_sum to zero and drops any pending response.
module subset_sum_backtracking (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ssb_pkg::req_word_type        req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ssb_pkg::rsp_word_type        rsp_word,
   input  logic                         csr_write,
   input  logic [ssb_pkg::SUM_BITS-1:0] csr_wdata
);
   import ssb_pkg::*;

   // Command and status between the sequencer and the search datapath.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   ssb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

@@ rtl/ssb_checker.sv @@
`timescale 1ns / 1ps

module ssb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input ssb_pkg::rsp_word_type        rsp_word
);
   import ssb_pkg::*;

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response changed");

   // Only a solution carries a nonzero mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_SOLUTION) |-> (rsp_word.subset_mask == '0))
      else $error("mask set on a non-solution response");

   // Reset drops any pending response.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Only one request is in flight: an accepted word blocks the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   // A new request cannot produce a response in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared too early");

endmodule

bind subset_sum_backtracking ssb_checker u_checker (.*);
